>>> rtl/core/b58_pkg.sv
// Shared types, widths and the base58 alphabet lookup for the base58 decoder.
package b58_pkg;

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 3;

  // queue between front and back; depth is a power of two so pointers wrap
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic               last;
    logic               bad;
    logic [DIGIT_W-1:0] digit;
  } qentry_t;

  // Alphabet 1-9 A-H J-N P-Z a-k m-z; anything else is digit zero and bad.
  function automatic qentry_t classify(input logic [CHAR_W-1:0] code,
                                       input logic last);
    qentry_t            e;
    logic [CHAR_W-1:0]  d;
    logic               ok;
    ok = 1'b1;
    d  = '0;
    case (code) inside
      [8'h31:8'h39]: d = code - 8'h31;  // '1'..'9'
      [8'h41:8'h48]: d = code - 8'h38;  // 'A'..'H'
      [8'h4a:8'h4e]: d = code - 8'h39;  // 'J'..'N'
      [8'h50:8'h5a]: d = code - 8'h3a;  // 'P'..'Z'
      [8'h61:8'h6b]: d = code - 8'h40;  // 'a'..'k'
      [8'h6d:8'h7a]: d = code - 8'h41;  // 'm'..'z'
      default: begin
        ok = 1'b0;
        d  = '0;
      end
    endcase
    e.last  = last;
    e.bad   = ~ok;
    e.digit = d[DIGIT_W-1:0];
    return e;
  endfunction

endpackage

>>> rtl/core/b58_char_if.sv
// Character request channel: one ASCII code and an end-of-string mark.
interface b58_char_if;
  logic                       valid;
  logic                       ready;
  logic [b58_pkg::CHAR_W-1:0] char_code;
  logic                       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/core/b58_word_if.sv
// Result request channel: one decoded word with its index and flags.
interface b58_word_if;
  logic                        valid;
  logic                        ready;
  logic [b58_pkg::INDEX_W-1:0] word_index;
  logic [b58_pkg::WORD_W-1:0]  word_value;
  logic                        bad_char;
  logic                        last_word;

  modport source (output valid, output word_index, output word_value,
                  output bad_char, output last_word, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input bad_char, input last_word, output ready);
endinterface

>>> rtl/core/b58_front.sv
// Front end: accepts characters and classifies them into digit entries.
module b58_front (
  b58_char_if.sink          chars,
  output logic              push_valid,
  output b58_pkg::qentry_t  push_entry,
  input  logic              push_ready
);

  assign chars.ready = push_ready;
  assign push_valid  = chars.valid;
  assign push_entry  = b58_pkg::classify(chars.char_code, chars.last_char);

endmodule

>>> rtl/core/b58_queue.sv
// Short FIFO of classified digit entries between front and back.
module b58_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  b58_pkg::qentry_t  push_entry,
  output logic              push_ready,
  output logic              pop_valid,
  output b58_pkg::qentry_t  pop_entry,
  input  logic              pop_ready
);

  b58_pkg::qentry_t               mem [b58_pkg::QDEPTH];
  logic [b58_pkg::QPTR_W-1:0]     wr_ptr;
  logic [b58_pkg::QPTR_W-1:0]     rd_ptr;
  logic [b58_pkg::QCNT_W-1:0]     count;
  logic                           push;
  logic                           pop;

  assign push_ready = count != b58_pkg::QCNT_W'(b58_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + b58_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + b58_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + b58_pkg::QCNT_W'(1);
        2'b01:   count <= count - b58_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

>>> rtl/core/b58_back.sv
// Back end: multiply-accumulate by 58, snapshot on end of string, word emitter.
module b58_back #(
  parameter int NUM_WORDS = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  b58_pkg::qentry_t  q_entry,
  output logic              q_ready,
  b58_word_if.source        words
);

  localparam int ACC_W = b58_pkg::WORD_W * NUM_WORDS;
  localparam int IDX_W = $clog2(NUM_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);
  localparam logic [b58_pkg::INDEX_W-1:0] LAST_WIDX = b58_pkg::INDEX_W'(NUM_WORDS - 1);

  logic [ACC_W-1:0]              acc;
  logic                          err_seen;
  logic [ACC_W-1:0]              fold;
  logic                          fold_err;
  logic [ACC_W-1:0]              snap;
  logic                          snap_err;
  logic                          busy;
  logic [IDX_W-1:0]              emit_idx;
  logic [IDX_W+2:0]              emit_idx_ext;
  logic [b58_pkg::WORD_W-1:0]    top_word;
  logic                          out_valid;
  logic                          slot_free;
  logic                          emit_fire;
  logic                          emit_last;
  logic                          snap_free;
  logic                          pop;
  logic                          pop_last;

  // acc*58 = acc*32 + acc*16 + acc*8 + acc*2, wrapping at the top word
  assign fold = (acc << 5) + (acc << 4) + (acc << 3) + (acc << 1)
              + {{(ACC_W - b58_pkg::DIGIT_W){1'b0}}, q_entry.digit};
  assign fold_err = err_seen | q_entry.bad;

  assign slot_free = !out_valid || words.ready;
  assign emit_fire = busy && slot_free;
  assign emit_last = emit_idx == LAST_IDX;
  // a new string end may reload the snapshot as its final word leaves
  assign snap_free = !busy || (emit_fire && emit_last);
  assign q_ready   = !q_entry.last || snap_free;
  assign pop       = q_valid && q_ready;
  assign pop_last  = pop && q_entry.last;

  assign top_word     = snap[ACC_W-1 -: b58_pkg::WORD_W];
  assign emit_idx_ext = {3'b000, emit_idx};
  assign words.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      err_seen  <= 1'b0;
      busy      <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (q_entry.last) begin
          acc      <= '0;
          err_seen <= 1'b0;
        end else begin
          acc      <= fold;
          err_seen <= fold_err;
        end
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (words.ready) begin
        out_valid <= 1'b0;
      end

      if (pop_last) begin
        busy     <= 1'b1;
        emit_idx <= '0;
      end else if (emit_fire) begin
        emit_idx <= emit_idx + IDX_W'(1);
        if (emit_last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      snap     <= fold;
      snap_err <= fold_err;
    end else if (emit_fire) begin
      snap <= snap << b58_pkg::WORD_W;
    end

    if (emit_fire) begin
      words.word_index <= emit_idx_ext[b58_pkg::INDEX_W-1:0];
      words.bad_char   <= snap_err;
      words.last_word  <= emit_last;
      if (emit_idx == '0) begin
        words.word_value <= {{(b58_pkg::WORD_W - b58_pkg::BYTE_W){1'b0}},
                             top_word[b58_pkg::BYTE_W-1:0]};
      end else begin
        words.word_value <= top_word;
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> emit_idx <= LAST_IDX)
    else $error("emit index past last word");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    pop_last |=> (acc == '0) && !err_seen)
    else $error("accumulator not cleared after string end");

  a_snapshot_loaded: assert property (@(posedge clk) disable iff (rst)
    pop_last |=> busy && (emit_idx == '0))
    else $error("emitter not started after string end");

  a_last_word_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && words.last_word) |-> words.word_index == LAST_WIDX)
    else $error("last word flagged at wrong index");
`endif

endmodule

>>> rtl/core/base58_decode_accumulator.sv
// Top level of the streaming base58 decoder.
//
// Takes one base58 character per cycle while nothing stalls it; the digit is
// folded into a NUM_WORDS x 32-bit accumulator (times 58 plus digit, wrapping)
// as it leaves a two-entry queue behind the classifier. A character marked
// last loads a snapshot of the result and clears the accumulator, so the next
// string is folded while the snapshot drains NUM_WORDS words, most significant
// first, at one word per cycle while the receiver is ready, through a
// registered output. Sustained rate is one character per cycle while no string
// end is held back; a further string end waits until the snapshot has moved
// its last word into the output register.
// Characters outside the alphabet count as zero and set the sticky bad flag.
module base58_decode_accumulator #(
  parameter int NUM_WORDS = 7
) (
  input  logic       clk,
  input  logic       rst,
  b58_char_if.sink   chars,
  b58_word_if.source words
);

  logic              push_valid;
  logic              push_ready;
  b58_pkg::qentry_t  push_entry;
  logic              q_valid;
  logic              q_ready;
  b58_pkg::qentry_t  q_entry;

  b58_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  b58_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop_ready  (q_ready)
  );

  b58_back #(
    .NUM_WORDS (NUM_WORDS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_ready (q_ready),
    .words   (words)
  );

endmodule
